// File: sv/bdsa_pkg.sv
// Package for the button debounce and setpoint adjust block.
// Holds the register indexes, reset values, per-button state type and the
// debounce and divide-by-ten functions. Depends on nothing.
package bdsa_pkg;

	localparam int NUM_BTN = 3;
	localparam int BTN_SELECT = 0;
	localparam int BTN_UP = 1;
	localparam int BTN_DOWN = 2;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 10;
	localparam int IN_DATA_W = 8;
	localparam int OUT_DATA_W = 32;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_HOLD_SELECT = 3'd0,
		REG_HOLD_UP     = 3'd1,
		REG_HOLD_DOWN   = 3'd2,
		REG_ADJUST_STEP = 3'd3,
		REG_REPEAT      = 3'd4
	} cfg_reg_t;

	localparam logic [7:0]  HOLD_SELECT_RESET = 8'd5;
	localparam logic [7:0]  HOLD_UP_RESET     = 8'd5;
	localparam logic [7:0]  HOLD_DOWN_RESET   = 8'd10;
	localparam logic [9:0]  ADJUST_STEP_RESET = 10'd10;
	localparam logic [7:0]  REPEAT_RESET      = 8'd15;
	localparam logic [15:0] SETPOINT_RESET    = 16'd500;

	localparam logic [7:0]  TIMER_CAP    = 8'd200;
	localparam logic [7:0]  TIMER_REWIND = 8'd100;
	localparam logic [7:0]  TIMER_MAX    = 8'd255;
	localparam logic [15:0] RECIP_TEN    = 16'd52429;

	typedef struct packed {
		logic       active;
		logic [7:0] on_timer;
		logic       lockout;
		logic [7:0] off_timer;
	} btn_state_t;

	function automatic btn_state_t debounce(input btn_state_t cur, input logic released,
			input logic [7:0] hold);
		btn_state_t nxt;
		nxt = cur;
		if (!released && !nxt.lockout) begin
			nxt.active = 1'b1;
		end
		if (nxt.active) begin
			nxt.on_timer = nxt.on_timer + 8'd1;
			if (nxt.on_timer > TIMER_CAP) begin
				nxt.on_timer = TIMER_REWIND;
			end
		end
		if (nxt.on_timer > hold && released) begin
			nxt.active = 1'b0;
			nxt.on_timer = '0;
			nxt.lockout = 1'b1;
			nxt.off_timer = '0;
		end
		if (nxt.lockout && nxt.off_timer != TIMER_MAX) begin
			nxt.off_timer = nxt.off_timer + 8'd1;
		end
		if (nxt.off_timer > hold) begin
			nxt.lockout = 1'b0;
		end
		return nxt;
	endfunction

	// Signed divide by ten, truncated toward zero, low byte only.
	// The reciprocal multiply is exact for magnitudes up to 2^15.
	function automatic logic [7:0] div10_byte(input logic [15:0] value);
		logic        neg;
		logic [16:0] mag;
		logic [32:0] prod;
		logic [13:0] quo;
		logic [7:0]  res;
		neg = value[15];
		mag = neg ? (17'd0 - {1'b1, value}) : {1'b0, value};
		prod = {16'd0, mag} * {17'd0, RECIP_TEN};
		quo = prod[32:19];
		res = neg ? (8'd0 - quo[7:0]) : quo[7:0];
		return res;
	endfunction

endpackage

// File: sv/button_debounce_setpoint_adjust.sv
// Top level of the button debounce and setpoint adjust block.
// Uses bdsa_pkg for the state type, register indexes and functions.
//
// Each input item is one tick with three active-low button levels in
// s_tdata. Each tick gives exactly one result item on the m_ side with the
// debounced latches, the new setpoint and, while select is active, the old
// setpoint divided by ten as a send byte. The user must write configuration
// registers through cfg_we, cfg_addr and cfg_wdata only while no item is in
// flight; the block itself does not enforce this. An accepted item waits in
// the input register while the debounce and setpoint logic runs on it, then
// moves to the output register, which the m_ side reads, once that is free
// or being taken; the state updates as it moves. Throughput is one item per
// cycle while the receiver does not stall; the per-tick state update is the
// single combinational step between the two registers. When the receiver
// stalls, the output register holds its item, the input register still
// fills, and s_tready drops once both are full. Reset clears all button
// state, loads the setpoint with 500, the repeat delays with zero and the
// registers with their defaults, and empties both stages.
module button_debounce_setpoint_adjust (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// select_level [0], up_level [1], down_level [2], zeros above.
	input  logic [bdsa_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// select_active [0], up_active [1], down_active [2], setpoint_value [18:3],
	// send_valid [19], send_byte [27:20], zeros above.
	output logic [bdsa_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                               cfg_we,
	input  logic [bdsa_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [bdsa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import bdsa_pkg::*;

	logic [7:0] hold_q [NUM_BTN];
	logic [9:0] step_q;
	logic [7:0] repeat_q;

	btn_state_t btn_q [NUM_BTN];
	btn_state_t btn_nxt [NUM_BTN];
	logic [15:0] setpoint_q, setpoint_nxt;
	logic [7:0]  up_delay_q, up_delay_nxt;
	logic [7:0]  down_delay_q, down_delay_nxt;
	logic        send_valid;
	logic [7:0]  send_byte;

	logic        valid_s1;
	logic [2:0]  levels_s1;
	logic        out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic        advance;

	assign advance = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q[BTN_SELECT] <= HOLD_SELECT_RESET;
			hold_q[BTN_UP] <= HOLD_UP_RESET;
			hold_q[BTN_DOWN] <= HOLD_DOWN_RESET;
			step_q <= ADJUST_STEP_RESET;
			repeat_q <= REPEAT_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_HOLD_SELECT: hold_q[BTN_SELECT] <= cfg_wdata[7:0];
				REG_HOLD_UP:     hold_q[BTN_UP] <= cfg_wdata[7:0];
				REG_HOLD_DOWN:   hold_q[BTN_DOWN] <= cfg_wdata[7:0];
				REG_ADJUST_STEP: step_q <= cfg_wdata;
				REG_REPEAT:      repeat_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_BTN; i++) begin
			btn_nxt[i] = debounce(btn_q[i], levels_s1[i], hold_q[i]);
		end
		setpoint_nxt = setpoint_q;
		up_delay_nxt = up_delay_q;
		down_delay_nxt = down_delay_q;
		send_valid = 1'b0;
		send_byte = '0;
		if (btn_nxt[BTN_SELECT].active) begin
			send_valid = 1'b1;
			send_byte = div10_byte(setpoint_q);
			if (btn_nxt[BTN_UP].active && up_delay_q == 8'd0) begin
				setpoint_nxt = setpoint_nxt + {6'd0, step_q};
				up_delay_nxt = repeat_q;
			end
			if (up_delay_nxt != 8'd0) begin
				up_delay_nxt = up_delay_nxt - 8'd1;
			end
			if (btn_nxt[BTN_DOWN].active && down_delay_q == 8'd0) begin
				setpoint_nxt = setpoint_nxt - {6'd0, step_q};
				down_delay_nxt = repeat_q;
			end
			if (down_delay_nxt != 8'd0) begin
				down_delay_nxt = down_delay_nxt - 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BTN; i++) begin
				btn_q[i] <= '0;
			end
			setpoint_q <= SETPOINT_RESET;
			up_delay_q <= '0;
			down_delay_q <= '0;
		end else if (advance) begin
			for (int i = 0; i < NUM_BTN; i++) begin
				btn_q[i] <= btn_nxt[i];
			end
			setpoint_q <= setpoint_nxt;
			up_delay_q <= up_delay_nxt;
			down_delay_q <= down_delay_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			levels_s1 <= s_tdata[2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {4'd0, send_byte, send_valid, setpoint_nxt,
				btn_nxt[BTN_DOWN].active, btn_nxt[BTN_UP].active,
				btn_nxt[BTN_SELECT].active};
		end
	end

endmodule
